@@ rtl/trlbr_pkg.sv @@
// ----------------------------------------------------------------------------
// trlbr_pkg
// Shared types, constants and the run length to bit count conversion for the
// threshold run-length bit recovery block.
// ----------------------------------------------------------------------------
package trlbr_pkg;

  // widths fixed by the item and result formats
  localparam int SAMPLE_W = 16;
  localparam int RUN_W    = 8;
  localparam int COPIES_W = 7;

  // default saturation point of the run counters
  localparam int MAX_RUN_DEFAULT = 203;

  // depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // bits = round(len * 0.3145728), done as (len * K + 2^23) >> 24
  localparam int                 RTB_SHIFT = 24;
  localparam logic [22:0]        RTB_MUL   = 23'd5277656;
  localparam logic [RTB_SHIFT:0] RTB_HALF  = (RTB_SHIFT + 1)'(1) << (RTB_SHIFT - 1);

  // input item codes
  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_FLUSH  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_VALID     = 2'd1,
    REG_POLARITY  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    action_t                     action;
    logic signed [SAMPLE_W-1:0]  sample_value;
  } item_t;

  typedef struct packed {
    logic out_bit;
    logic last_of_run;
  } result_t;

  // configuration seen by the front
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] slice_threshold;
    logic                       threshold_valid;
    logic                       polarity_inverted;
  } cfg_t;

  // one queued run of identical bits
  typedef struct packed {
    logic                bit_value;
    logic [COPIES_W-1:0] copies;
  } job_t;

  // converted bit count of a run length
  function automatic logic [COPIES_W-1:0] run_to_bits(input logic [RUN_W-1:0] len);
    logic [RTB_SHIFT+RUN_W-1:0] prod;
    prod = (RTB_SHIFT + RUN_W)'(len) * (RTB_SHIFT + RUN_W)'(RTB_MUL)
         + (RTB_SHIFT + RUN_W)'(RTB_HALF);
    return prod[RTB_SHIFT +: COPIES_W];
  endfunction

endpackage

@@ rtl/trlbr_front.sv @@
// ----------------------------------------------------------------------------
// trlbr_front
// Accepts items, slices samples, keeps the run counters and turns each item
// into at most one queued job of identical bits.
// ----------------------------------------------------------------------------
module trlbr_front import trlbr_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item_data,
  input  logic  queue_full,
  output logic  push,
  output job_t  push_job
);

  localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(MAX_RUN);

  logic [RUN_W-1:0]    high_run_count, high_run_count_next;
  logic [RUN_W-1:0]    low_run_count, low_run_count_next;
  logic                accept;
  logic                is_high;
  logic [RUN_W-1:0]    own_len;
  logic [RUN_W-1:0]    own_bumped;
  logic [RUN_W-1:0]    conv_len;
  logic [COPIES_W-1:0] conv_bits;
  logic                flush_high;

  assign item_stall = queue_full;
  assign accept     = item_valid & ~item_stall;

  // slice and pick the run being converted
  assign is_high    = item_data.sample_value >= cfg.slice_threshold;
  assign own_len    = is_high ? high_run_count : low_run_count;
  assign own_bumped = (own_len < RUN_LIMIT) ? own_len + RUN_W'(1) : RUN_LIMIT;
  assign flush_high = high_run_count != '0;
  assign conv_len   = (item_data.action == ACT_FLUSH)
                    ? (flush_high ? high_run_count : low_run_count)
                    : (is_high ? low_run_count : high_run_count);
  assign conv_bits  = run_to_bits(conv_len);

  // counter update and job generation
  always_comb begin
    high_run_count_next = high_run_count;
    low_run_count_next  = low_run_count;
    push                = 1'b0;
    push_job.bit_value  = 1'b0;
    push_job.copies     = conv_bits;
    unique case (item_data.action)
      ACT_SAMPLE: begin
        if (cfg.threshold_valid) begin
          if (is_high) begin
            high_run_count_next = own_bumped;
            low_run_count_next  = '0;
            push_job.bit_value  = cfg.polarity_inverted;
          end else begin
            low_run_count_next  = own_bumped;
            high_run_count_next = '0;
            push_job.bit_value  = ~cfg.polarity_inverted;
          end
          // first sample of a run gives at least one bit
          if (own_len == '0 && conv_bits == '0) begin
            push_job.copies = COPIES_W'(1);
          end
          push = 1'b1;
        end
      end
      ACT_FLUSH: begin
        if (cfg.threshold_valid) begin
          high_run_count_next = '0;
          low_run_count_next  = '0;
          push_job.bit_value  = flush_high ? cfg.polarity_inverted : ~cfg.polarity_inverted;
          push                = 1'b1;
        end
      end
      ACT_CLEAR: begin
        high_run_count_next = '0;
        low_run_count_next  = '0;
      end
      ACT_NOP: begin
      end
      default: begin
      end
    endcase
    // runs that convert to nothing are not queued
    if (!accept || push_job.copies == '0) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_run_count <= '0;
      low_run_count  <= '0;
    end else if (accept) begin
      high_run_count <= high_run_count_next;
      low_run_count  <= low_run_count_next;
    end
  end

endmodule

@@ rtl/trlbr_queue.sv @@
// ----------------------------------------------------------------------------
// trlbr_queue
// Short first-in first-out queue of bit jobs between front and back.
// ----------------------------------------------------------------------------
module trlbr_queue import trlbr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign empty = fill == '0;
  assign full  = fill == CNT_W'(QUEUE_DEPTH);
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/trlbr_back.sv @@
// ----------------------------------------------------------------------------
// trlbr_back
// Takes jobs from the queue and sends one result beat per bit copy, marking
// the final copy of each job.
// ----------------------------------------------------------------------------
module trlbr_back import trlbr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    queue_empty,
  input  job_t    head,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result_data
);

  logic                busy;
  logic                cur_bit;
  logic [COPIES_W-1:0] remain;
  logic                fire;
  logic                done;

  assign result_valid            = busy;
  assign result_data.out_bit     = cur_bit;
  assign result_data.last_of_run = remain == COPIES_W'(1);

  assign fire = busy & ~result_stall;
  assign done = ~busy | (fire & result_data.last_of_run);
  assign pop  = done & ~queue_empty;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (done) begin
      busy <= ~queue_empty;
    end
  end

  // current job
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_bit <= head.bit_value;
      remain  <= head.copies;
    end else if (fire) begin
      remain  <= remain - COPIES_W'(1);
    end
  end

endmodule

@@ rtl/threshold_run_length_bit_recovery.sv @@
// ----------------------------------------------------------------------------
// threshold_run_length_bit_recovery
// Slices signed samples against a threshold and recovers data bits from the
// lengths of high and low runs.
// ----------------------------------------------------------------------------
// The block takes one item per cycle as long as its four-entry job queue has
// room; each item is classified and the run counters are updated in the cycle
// it is taken. An item that produces bits leaves one queued job of N identical
// bits, and the back end sends those N bits as N result beats, one per cycle
// while result_stall is low, with last_of_run on the final one. Each job is
// written into the queue and then loaded into the back end's job registers,
// which drive its beats.
// Configuration writes are always taken (cfg_ready is tied high) and must be
// done while no item is in flight.
module threshold_run_length_bit_recovery import trlbr_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  item_t               item_data,
  output logic                result_valid,
  input  logic                result_stall,
  output result_t             result_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [SAMPLE_W-1:0] cfg_data
);

  cfg_t cfg;
  logic queue_full;
  logic queue_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slice_threshold   <= '0;
      cfg.threshold_valid   <= 1'b0;
      cfg.polarity_inverted <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD: cfg.slice_threshold   <= cfg_data;
        REG_VALID:     cfg.threshold_valid   <= cfg_data[0];
        REG_POLARITY:  cfg.polarity_inverted <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // classify items, keep run counters
  trlbr_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_data  (item_data),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  // job queue
  trlbr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (queue_empty),
    .full     (queue_full)
  );

  // result beat generation
  trlbr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .queue_empty  (queue_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

@@ verif/trlbr_bit_checker.sv @@
// ----------------------------------------------------------------------------
// trlbr_bit_checker
// Watches the item, result and configuration channels of the run-length bit
// recovery block. It predicts the recovered bits of every accepted item and
// compares each result beat with the oldest expected bit.
// ----------------------------------------------------------------------------
module trlbr_bit_checker import trlbr_pkg::*; #(
  parameter int RUN_LIMIT = MAX_RUN_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_stall,
  input  item_t               item_data,
  input  logic                result_valid,
  input  logic                result_stall,
  input  result_t             result_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [SAMPLE_W-1:0] cfg_data,
  output int                  mismatches,
  output int                  pending_beats,
  output int                  checked_beats
);

  // shadow of the configuration registers
  logic signed [SAMPLE_W-1:0] shadow_threshold;
  logic                       shadow_enable;
  logic                       shadow_polarity;

  // shadow run counters
  logic [RUN_W-1:0] high_len;
  logic [RUN_W-1:0] low_len;

  // bits recovered from the current item, and the bits still owed by the block
  result_t burst_bits [0:63];
  int      burst_len;
  result_t expected_bits [$];

  int fail_total;
  int pending_q;
  int checked_q;

  assign mismatches    = fail_total;
  assign pending_beats = pending_q;
  assign checked_beats = checked_q;

  // round(len * 0.3145728), half up, in exact integers
  function automatic int run_bit_count(logic [RUN_W-1:0] len);
    return (2 * int'(len) * 24576 + 78125) / 156250;
  endfunction

  function automatic logic [RUN_W-1:0] run_step(logic [RUN_W-1:0] len);
    return (int'(len) < RUN_LIMIT) ? len + 1'b1 : RUN_W'(RUN_LIMIT);
  endfunction

  // add copies of one bit to the burst, capped at 64 beats
  task automatic append_bits(logic bit_value, int copies);
    for (int i = 0; i < copies && burst_len < 64; i++) begin
      burst_bits[burst_len].out_bit     = bit_value;
      burst_bits[burst_len].last_of_run = 1'b0;
      burst_len++;
    end
  endtask

  // work out the bits one item causes and queue them
  task automatic recover_bits(item_t it);
    logic high_bit;
    logic low_bit;
    int   copies;
    result_t beat;
    high_bit  = shadow_polarity;
    low_bit   = ~shadow_polarity;
    burst_len = 0;
    case (it.action)
      ACT_CLEAR: begin
        high_len = '0;
        low_len  = '0;
      end
      ACT_SAMPLE: begin
        if (shadow_enable) begin
          if ($signed(it.sample_value) >= shadow_threshold) begin
            high_len = run_step(high_len);
            copies   = run_bit_count(low_len);
            // first sample of a run always gives at least one bit
            if (high_len == 1 && copies == 0) copies = 1;
            append_bits(high_bit, copies);
            low_len = '0;
          end else begin
            low_len = run_step(low_len);
            copies  = run_bit_count(high_len);
            if (low_len == 1 && copies == 0) copies = 1;
            append_bits(low_bit, copies);
            high_len = '0;
          end
        end
      end
      ACT_FLUSH: begin
        if (shadow_enable) begin
          if (high_len != 0) begin
            append_bits(high_bit, run_bit_count(high_len));
            high_len = '0;
          end
          if (low_len != 0) begin
            append_bits(low_bit, run_bit_count(low_len));
            low_len = '0;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < burst_len; i++) begin
      beat             = burst_bits[i];
      beat.last_of_run = (i == burst_len - 1);
      expected_bits.push_back(beat);
    end
  endtask

  // compare one result beat with the oldest expected bit
  task automatic check_beat(result_t got);
    result_t want;
    if (expected_bits.size() == 0) begin
      $error("unexpected result beat: out_bit %0b last_of_run %0b",
             got.out_bit, got.last_of_run);
      fail_total++;
    end else begin
      want = expected_bits.pop_front();
      checked_q++;
      if (got.out_bit !== want.out_bit) begin
        $error("out_bit mismatch: expected %0b actual %0b", want.out_bit, got.out_bit);
        fail_total++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run mismatch: expected %0b actual %0b",
               want.last_of_run, got.last_of_run);
        fail_total++;
      end
    end
  endtask

  initial begin
    fail_total = 0;
    pending_q  = 0;
    checked_q  = 0;
  end

  // channel monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      shadow_threshold = '0;
      shadow_enable    = 1'b0;
      shadow_polarity  = 1'b0;
      high_len         = '0;
      low_len          = '0;
      expected_bits.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD: shadow_threshold = $signed(cfg_data);
          REG_VALID:     shadow_enable    = cfg_data[0];
          REG_POLARITY:  shadow_polarity  = cfg_data[0];
          default: ;
        endcase
      end
      // a beat at this edge never belongs to an item taken at the same edge
      if (result_valid && !result_stall) check_beat(result_data);
      if (item_valid && !item_stall) recover_bits(item_data);
    end
    pending_q = expected_bits.size();
  end

endmodule

@@ verif/threshold_run_length_bit_recovery_tb.sv @@
// ----------------------------------------------------------------------------
// threshold_run_length_bit_recovery_tb
// Drives sample, flush and clear items through the bit recovery block under
// several threshold and polarity settings, with random gaps on the item channel
// and stalls on the result channel, and gives the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module threshold_run_length_bit_recovery_tb;
  import trlbr_pkg::*;

  localparam int LONG_HOLD  = 150;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE     = 10;

  logic                clk;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  logic                item_stall;
  item_t               item_data    = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  result_t             result_data;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index    = '0;
  logic [SAMPLE_W-1:0] cfg_data     = '0;

  int mismatches;
  int pending_beats;
  int checked_beats;

  // stimulus state
  int   cur_th;
  logic quiet       = 1'b0;
  int   holds_req   = 0;
  int   holds_done  = 0;
  int   items_sent  = 0;
  int   settings    = 0;
  int   run_left    = 0;
  logic run_high    = 1'b0;

  threshold_run_length_bit_recovery #(
    .MAX_RUN(MAX_RUN_DEFAULT)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item_data   (item_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data (result_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  trlbr_bit_checker #(
    .RUN_LIMIT(MAX_RUN_DEFAULT)
  ) bit_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_data    (item_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending_beats(pending_beats),
    .checked_beats(checked_beats)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic item_t mk(action_t a, int v);
    item_t it;
    it.action       = a;
    it.sample_value = 16'(v);
    return it;
  endfunction

  // sample on the requested side of the current threshold
  function automatic item_t make_sample(logic want_high);
    int lo;
    int hi;
    if (!want_high && cur_th == -32768) want_high = 1'b1;
    if (want_high) begin
      lo = cur_th;
      hi = 32767;
    end else begin
      lo = -32768;
      hi = cur_th - 1;
    end
    return mk(ACT_SAMPLE, lo + int'($urandom_range(0, hi - lo)));
  endfunction

  // sender gap, mostly short
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // offer one item, hold it until taken, then maybe idle; called at a falling edge
  task automatic send_item(item_t it);
    int gap;
    item_valid <= 1'b1;
    item_data  <= it;
    do @(posedge clk); while (item_stall);
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(cfg_index_t idx, logic [SAMPLE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(int th, logic enable, logic pol);
    write_reg(REG_THRESHOLD, 16'(th));
    write_reg(REG_VALID, {15'd0, enable});
    write_reg(REG_POLARITY, {15'd0, pol});
    cur_th = th;
    settings++;
  endtask

  // wait for every owed bit, then let the queue settle
  task automatic drain();
    item_valid <= 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // mostly well-formed runs, some flushes, clears and noise
  task automatic next_item(output item_t it);
    int r;
    r = $urandom_range(0, 99);
    if (r < 84) begin
      if (run_left == 0) begin
        run_high = ~run_high;
        run_left = ($urandom_range(0, 99) < 3) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 14);
      end
      it = make_sample(run_high);
      run_left--;
    end else if (r < 90) begin
      it = mk(ACT_FLUSH, $urandom_range(0, 65535));
    end else if (r < 94) begin
      it = mk(ACT_CLEAR, $urandom_range(0, 65535));
    end else if (r < 96) begin
      it = mk(ACT_NOP, $urandom_range(0, 65535));
    end else begin
      it = mk(ACT_SAMPLE, $urandom_range(0, 65535));
    end
  endtask

  task automatic random_items(int count);
    item_t it;
    for (int i = 0; i < count; i++) begin
      next_item(it);
      send_item(it);
    end
  endtask

  // result receiver: random stalls, plus long hold-offs on request
  initial begin : result_sink
    int   seg;
    logic stalling;
    seg      = 0;
    stalling = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < holds_req) begin
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
        seg = 0;
      end else if (quiet) begin
        result_stall <= 1'b0;
      end else begin
        if (seg == 0) begin
          stalling = ($urandom_range(0, 99) < 35);
          if (!stalling) seg = $urandom_range(1, 25);
          else if ($urandom_range(0, 99) < 80) seg = $urandom_range(1, 3);
          else if ($urandom_range(0, 99) < 75) seg = $urandom_range(4, 12);
          else seg = $urandom_range(25, 60);
        end
        result_stall <= stalling;
        seg--;
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // main sequence
  initial begin
    cur_th = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // disabled after reset: samples and flushes ignored, clear and unused action
    send_item(mk(ACT_SAMPLE, 32767));
    send_item(mk(ACT_SAMPLE, -32768));
    send_item(mk(ACT_FLUSH, 0));
    send_item(mk(ACT_NOP, 'hffff));
    send_item(mk(ACT_CLEAR, 'h5555));
    drain();

    // directed runs at threshold 0
    set_config(0, 1'b1, 1'b0);
    send_item(mk(ACT_SAMPLE, 0));
    send_item(mk(ACT_SAMPLE, 32767));
    send_item(mk(ACT_SAMPLE, -1));
    send_item(mk(ACT_SAMPLE, -32768));
    send_item(mk(ACT_SAMPLE, 32767));
    // flush of a one-sample run gives nothing
    send_item(mk(ACT_FLUSH, 'haaaa));
    send_item(mk(ACT_SAMPLE, 100));
    send_item(mk(ACT_NOP, 'h1234));
    repeat (4) send_item(mk(ACT_SAMPLE, 200));
    send_item(mk(ACT_FLUSH, 0));
    send_item(mk(ACT_SAMPLE, -5));
    send_item(mk(ACT_CLEAR, 0));
    send_item(mk(ACT_SAMPLE, 7));
    send_item(mk(ACT_SAMPLE, -7));
    send_item(mk(ACT_FLUSH, 0));
    drain();

    // random runs with a long receiver hold-off at the start
    set_config(0, 1'b1, 1'b1);
    holds_req++;
    random_items(70);
    drain();

    // lowest threshold: every sample is high
    set_config(-32768, 1'b1, 1'b1);
    random_items(25);
    drain();

    // highest threshold: only full scale is high
    set_config(32767, 1'b1, 1'b0);
    random_items(40);
    drain();

    // saturated run, then the 64-bit burst under a long hold-off
    set_config(int'($signed(16'($urandom_range(0, 65535)))), 1'b1,
               1'($urandom_range(0, 1)));
    send_item(mk(ACT_CLEAR, 0));
    repeat (205) send_item(make_sample(1'b1));
    holds_req++;
    send_item(make_sample(1'b0));
    run_high = 1'b0;
    run_left = $urandom_range(1, 14);
    random_items(14);
    drain();

    // disabled again: samples and flushes ignored, counters kept unless cleared
    set_config(cur_th, 1'b0, 1'b1);
    random_items(15);
    drain();

    // back to back with no idling
    set_config(int'($signed(16'($urandom_range(0, 65535)))), 1'b1,
               1'($urandom_range(0, 1)));
    quiet = 1'b1;
    random_items(50);
    drain();
    quiet = 1'b0;

    $display("covered %0d items over %0d register settings, %0d result beats checked",
             items_sent, settings, checked_beats);
    $display("including threshold extremes, saturated runs, short flushes and %0d hold-offs",
             holds_done);
    if (mismatches == 0 && pending_beats == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
